// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: name");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: name");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// tle_pkg
// shared types, character codes and echo run tables of the line editor
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

   localparam int LINE_CAPACITY = 128;
   localparam int USABLE_LEN    = LINE_CAPACITY - 1;
   localparam int IDX_W         = $clog2(LINE_CAPACITY);
   localparam int STEP_W        = 3;

   typedef logic [7:0]        byte_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [STEP_W-1:0] step_type;

   localparam byte_type CH_BS      = 8'h08;
   localparam byte_type CH_LF      = 8'h0A;
   localparam byte_type CH_CR      = 8'h0D;
   localparam byte_type CH_ESC     = 8'h1B;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_HASH    = 8'h23;
   localparam byte_type CH_AT      = 8'h40;
   localparam byte_type CH_C       = 8'h43;
   localparam byte_type CH_D       = 8'h44;
   localparam byte_type CH_P       = 8'h50;
   localparam byte_type CH_LBRACK  = 8'h5B;
   localparam byte_type CH_DEL     = 8'h7F;
   localparam byte_type LOW_MASK   = 8'h7F;
   localparam byte_type PRINT_MASK = 8'h60;

   localparam idx_type  LINE_FULL  = idx_type'(USABLE_LEN);

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   // broadcast to every cell of the line store
   typedef struct packed {
      cell_op_type op;
      idx_type     pos;
      idx_type     length;
      byte_type    data;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      RUN_CHAR,
      RUN_INSERT,
      RUN_BACKSPACE,
      RUN_RIGHT,
      RUN_LEFT,
      RUN_ENTER
   } run_type;

   typedef struct packed {
      logic     go;
      run_type  kind;
      byte_type ch;
   } run_req_type;

   function automatic step_type run_length(run_type kind);
      step_type n;
      case (kind)
         RUN_CHAR:      n = step_type'(1);
         RUN_INSERT:    n = step_type'(4);
         RUN_BACKSPACE: n = step_type'(6);
         RUN_RIGHT:     n = step_type'(3);
         RUN_LEFT:      n = step_type'(3);
         RUN_ENTER:     n = step_type'(4);
         default:       n = step_type'(1);
      endcase
      return n;
   endfunction

   function automatic byte_type run_byte(run_type kind, step_type step, byte_type ch);
      byte_type b;
      b = ch;
      case (kind)
         RUN_CHAR: b = ch;
         RUN_INSERT: begin
            case (step)
               3'd0:    b = CH_ESC;
               3'd1:    b = CH_LBRACK;
               3'd2:    b = CH_AT;
               default: b = ch;
            endcase
         end
         RUN_BACKSPACE: begin
            case (step)
               3'd0, 3'd3: b = CH_ESC;
               3'd1, 3'd4: b = CH_LBRACK;
               3'd2:       b = CH_D;
               default:    b = CH_P;
            endcase
         end
         RUN_RIGHT, RUN_LEFT: begin
            case (step)
               3'd0:    b = CH_ESC;
               3'd1:    b = CH_LBRACK;
               default: b = (kind == RUN_RIGHT) ? CH_C : CH_D;
            endcase
         end
         RUN_ENTER: begin
            case (step)
               3'd0:    b = CH_CR;
               3'd1:    b = CH_LF;
               3'd2:    b = CH_HASH;
               default: b = CH_SPACE;
            endcase
         end
         default: b = ch;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tle_if.sv -----
// ----------------------------------------------------------------------------
// tle_if
// valid/ready channels of the line editor: received bytes and echo words
// ----------------------------------------------------------------------------
`default_nettype none

interface tle_req_if;
   logic               valid;
   logic               ready;
   tle_pkg::byte_type  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   logic               valid;
   logic               ready;
   tle_pkg::byte_type  tx_byte;
   logic               last;
   logic               line_done;

   modport source (output valid, output tx_byte, output last, output line_done, input ready);
   modport sink   (input valid, input tx_byte, input last, input line_done, output ready);
endinterface

`default_nettype wire

// ----- hdl/tle_cell.sv -----
// ----------------------------------------------------------------------------
// tle_cell
// one byte of the line store, shifts toward either neighbor on edits
// ----------------------------------------------------------------------------
`default_nettype none

module tle_cell (
   input  wire                         clock,
   input  wire tle_pkg::idx_type       cell_idx,
   input  wire tle_pkg::cell_cmd_type  cmd,
   input  wire tle_pkg::byte_type      left_byte,
   input  wire tle_pkg::byte_type      right_byte,
   output tle_pkg::byte_type           cell_byte
);
   import tle_pkg::*;

   byte_type                 data_ff;
   byte_type                 data_in;
   logic     [IDX_W:0]       idx_next;

   assign idx_next  = {1'b0, cell_idx} + (IDX_W+1)'(1);
   assign cell_byte = data_ff;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_idx == cmd.pos) begin
               data_in = cmd.data;
            end else if (cell_idx > cmd.pos && cell_idx <= cmd.length) begin
               data_in = left_byte;
            end
         end
         CELL_DELETE: begin
            // close the gap left of the cursor
            if (idx_next >= {1'b0, cmd.pos} && idx_next < {1'b0, cmd.length}) begin
               data_in = right_byte;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ----- hdl/tle_echo.sv -----
// ----------------------------------------------------------------------------
// tle_echo
// plays out one echo run, one word per handshake
// ----------------------------------------------------------------------------
`default_nettype none

module tle_echo (
   input  wire                        clock,
   input  wire                        reset,
   input  wire tle_pkg::run_req_type  run_req,
   output logic                       busy,
   tle_rsp_if.source                  rsp
);
   import tle_pkg::*;

   logic     busy_ff,  busy_in;
   step_type step_ff,  step_in;
   run_type  kind_ff,  kind_in;
   byte_type ch_ff,    ch_in;
   logic     final_step;

   assign final_step    = (step_ff == run_length(kind_ff) - step_type'(1));
   assign busy          = busy_ff;
   assign rsp.valid     = busy_ff;
   assign rsp.tx_byte   = run_byte(kind_ff, step_ff, ch_ff);
   assign rsp.last      = final_step;
   assign rsp.line_done = (kind_ff == RUN_ENTER);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      kind_in = kind_ff;
      ch_in   = ch_ff;
      if (busy_ff) begin
         if (rsp.ready) begin
            if (final_step) begin
               busy_in = 1'b0;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
      end else if (run_req.go) begin
         busy_in = 1'b1;
         step_in = '0;
         kind_in = run_req.kind;
         ch_in   = run_req.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      kind_ff <= kind_in;
      ch_ff   <= ch_in;
   end

endmodule

`default_nettype wire

// ----- hdl/terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// terminal_line_editor
// vt100 line editor: edits a command line held in a row of byte cells
// and echoes escape sequences back to the terminal
// ----------------------------------------------------------------------------
//  channel  dir  word                       meaning
//  req_ch   in   rx_byte                    received terminal byte
//  rsp_ch   out  tx_byte, last, line_done   echo byte, end of run, line ended
//
//  an accepted byte is decoded and applied to the line; the echo run
//  then plays out 0 to 6 words, one word per rsp_ch handshake, and the
//  echo sequencer sets the run length
//  req_ch.ready is low in reset and while a run plays out; rsp_ch stalls
//  freeze the run
//  synchronous reset clears length, cursor and history bytes; the line
//  store cells are not reset and read only below the line length
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module terminal_line_editor (
   input  wire        clock,
   input  wire        reset,
   tle_req_if.sink    req_ch,
   tle_rsp_if.source  rsp_ch
);
   import tle_pkg::*;

   // edit state
   idx_type      line_length_ff, line_length_in;
   idx_type      cursor_back_ff, cursor_back_in;
   byte_type     prior_ff,       prior_in;
   byte_type     prior2_ff,      prior2_in;

   logic         accept;
   logic         echo_busy;
   byte_type     c;
   byte_type     low;
   idx_type      cursor_pos;
   logic         esc_open;
   logic         esc_seq;
   logic         printable;
   cell_cmd_type cmd;
   run_req_type  run_req;

   byte_type     store_q [USABLE_LEN];

   // one word at a time: take a byte only when no run is pending
   assign req_ch.ready = !echo_busy && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign c            = req_ch.rx_byte;
   assign low          = c & LOW_MASK;
   assign cursor_pos   = line_length_ff - cursor_back_ff;

   // ESC [ opens a sequence, the byte after it is the final
   assign esc_open  = (prior_ff == CH_ESC) && (c == CH_LBRACK);
   assign esc_seq   = (prior_ff == CH_LBRACK) && (prior2_ff == CH_ESC);
   assign printable = ((low & PRINT_MASK) != '0) && (low != CH_DEL);

   always_comb begin
      line_length_in = line_length_ff;
      cursor_back_in = cursor_back_ff;
      prior_in       = prior_ff;
      prior2_in      = prior2_ff;
      cmd.op         = CELL_HOLD;
      cmd.pos        = cursor_pos;
      cmd.length     = line_length_ff;
      cmd.data       = c;
      run_req.go     = 1'b0;
      run_req.kind   = RUN_CHAR;
      run_req.ch     = c;

      if (accept) begin
         prior_in  = c;
         prior2_in = prior_ff;
         if (esc_open) begin
            // wait for the final byte
         end else if (esc_seq) begin
            if (c == CH_C && cursor_back_ff != '0) begin
               cursor_back_in = cursor_back_ff - idx_type'(1);
               run_req.go     = 1'b1;
               run_req.kind   = RUN_RIGHT;
            end else if (c == CH_D && cursor_back_ff < line_length_ff) begin
               cursor_back_in = cursor_back_ff + idx_type'(1);
               run_req.go     = 1'b1;
               run_req.kind   = RUN_LEFT;
            end
         end else if (printable) begin
            // full line drops the byte silently
            if (line_length_ff < LINE_FULL) begin
               line_length_in = line_length_ff + idx_type'(1);
               cmd.op         = CELL_INSERT;
               run_req.go     = 1'b1;
               run_req.kind   = (cursor_back_ff != '0) ? RUN_INSERT : RUN_CHAR;
            end
         end else if (c == CH_CR || (c == CH_LF && prior_ff != CH_CR)) begin
            line_length_in = '0;
            cursor_back_in = '0;
            run_req.go     = 1'b1;
            run_req.kind   = RUN_ENTER;
         end else if (c == CH_BS || c == CH_DEL) begin
            // nothing to erase at the start of the line
            if (cursor_pos != '0) begin
               line_length_in = line_length_ff - idx_type'(1);
               cmd.op         = CELL_DELETE;
               run_req.go     = 1'b1;
               run_req.kind   = RUN_BACKSPACE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         cursor_back_ff <= '0;
         prior_ff       <= '0;
         prior2_ff      <= '0;
      end else begin
         line_length_ff <= line_length_in;
         cursor_back_ff <= cursor_back_in;
         prior_ff       <= prior_in;
         prior2_ff      <= prior2_in;
      end
   end

   // line store: a row of cells, each passing its byte to a neighbor on edits
   for (genvar i = 0; i < USABLE_LEN; i++) begin : g_cell
      byte_type left_nb;
      byte_type right_nb;
      if (i == 0) begin : g_first
         assign left_nb = c;
      end else begin : g_left
         assign left_nb = store_q[i-1];
      end
      if (i == USABLE_LEN - 1) begin : g_end
         assign right_nb = '0;
      end else begin : g_right
         assign right_nb = store_q[i+1];
      end
      tle_cell u_cell (
         .clock      (clock),
         .cell_idx   (idx_type'(i)),
         .cmd        (cmd),
         .left_byte  (left_nb),
         .right_byte (right_nb),
         .cell_byte  (store_q[i])
      );
   end

   // echo sequencer
   tle_echo u_echo (
      .clock   (clock),
      .reset   (reset),
      .run_req (run_req),
      .busy    (echo_busy),
      .rsp     (rsp_ch)
   );

   `ASSERT_ALWAYS(a_cursor_in_line, clock, reset, cursor_back_ff <= line_length_ff)
   `ASSERT_ALWAYS(a_length_bound, clock, reset, line_length_ff <= LINE_FULL)
   `ASSERT_ALWAYS(a_no_take_while_echo, clock, reset, !(rsp_ch.valid && req_ch.ready))
   `ASSERT_NEXT(a_enter_clears, clock, reset, run_req.go && run_req.kind == RUN_ENTER, line_length_ff == '0 && cursor_back_ff == '0)
   `ASSERT_NEXT(a_run_starts, clock, reset, run_req.go, rsp_ch.valid)

endmodule

`default_nettype wire
